/* rtl/pps_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pps_pkg
// shared types and codes for the preemptive priority scheduler
// ---------------------------------------------------------------------------
package pps_pkg;
    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;
    localparam logic KIND_DONE  = 1'b0;
    localparam logic KIND_DROP  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] job_id;
        logic [31:0] arrival_time;
        logic [15:0] run_length;
        logic [7:0]  job_priority;
    } t_cmd;

    typedef struct packed {
        logic        kind;
        logic [15:0] done_id;
        logic [31:0] finish_time;
        logic        last;
    } t_res;

    function automatic logic beats(input logic [7:0] pa, input logic [31:0] aa,
                                   input logic [7:0] pb, input logic [31:0] ab);
        if (pa != pb) begin
            return pa > pb;
        end
        return aa < ab;
    endfunction
endpackage

/* rtl/preemptive_priority_scheduler.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// preemptive_priority_scheduler
// single-processor preemptive priority scheduler, queue interfaces both sides
// ---------------------------------------------------------------------------
// commands are pushed with i_push while o_full is low; results are read with
// i_pop while o_empty is low, oldest first, o_last marking the final one of a
// command. a two-word command queue parts the front from the engine, and a
// result queue parts the engine from the reader, so either side may stall.
// the engine scans the ready store one slot per cycle, once for each retired
// job, to pick the next one to run. a dropped arrival passes through a drop
// step in place of the admit step.
// when the reader stalls and the result queue fills, the engine waits; then
// the command queue fills and o_full rises.
// reset (synchronous, active low) empties both queues, clears all valid bits
// and idles the processor at time zero.
// ---------------------------------------------------------------------------
module preemptive_priority_scheduler import pps_pkg::*; #(
    parameter int READY_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_cmd,
    input  logic [15:0] i_job_id,
    input  logic [31:0] i_arrival_time,
    input  logic [15:0] i_run_length,
    input  logic [7:0]  i_job_priority,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_kind,
    output logic [15:0] o_done_id,
    output logic [31:0] o_finish_time,
    output logic        o_last
);
    t_cmd w_in, w_q;
    t_res w_res, w_out;
    logic w_q_empty, w_take, w_rpush, w_rfull;

    assign w_in = '{cmd: i_cmd, job_id: i_job_id, arrival_time: i_arrival_time,
                    run_length: i_run_length, job_priority: i_job_priority};

    pps_fifo #(.W($bits(t_cmd)), .DEPTH(2)) u_cmdq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_data(w_in),
        .o_full(o_full), .i_pop(w_take), .o_empty(w_q_empty), .o_data(w_q));

    pps_engine #(.READY_DEPTH(READY_DEPTH)) u_eng (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(!w_q_empty), .i_cmd(w_q),
        .o_cmd_take(w_take), .o_res_push(w_rpush), .o_res(w_res),
        .i_res_full(w_rfull));

    pps_fifo #(.W($bits(t_res)), .DEPTH(4)) u_resq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_rpush), .i_data(w_res),
        .o_full(w_rfull), .i_pop(i_pop), .o_empty(o_empty), .o_data(w_out));

    assign o_kind = w_out.kind;
    assign o_done_id = w_out.done_id;
    assign o_finish_time = w_out.finish_time;
    assign o_last = w_out.last;
endmodule

/* rtl/pps_fifo.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pps_fifo
// small register queue used between front and back and on the results
// ---------------------------------------------------------------------------
module pps_fifo #(
    parameter int W = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          w_push, w_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("fifo count overflow");
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |=> o_full) else $error("full dropped without pop");
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty && !i_push) |=> o_empty) else $error("empty left without push");
`endif
endmodule

/* rtl/pps_engine.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pps_engine
// back end: carries out one command, scanning the ready store per selection
// ---------------------------------------------------------------------------
module pps_engine import pps_pkg::*; #(
    parameter int READY_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_take,
    output logic o_res_push,
    output t_res o_res,
    input  logic i_res_full
);
    localparam int SW = $clog2(READY_DEPTH);
    localparam logic [2:0] S_IDLE = 3'd0, S_CHECK = 3'd1, S_SCAN = 3'd2,
                           S_EMIT = 3'd3, S_ADMIT = 3'd4, S_DROP = 3'd5;

    logic [2:0]  r_st, n_st;
    logic [READY_DEPTH-1:0] r_vld;
    logic [15:0] r_rid  [READY_DEPTH];
    logic [31:0] r_rarr [READY_DEPTH];
    logic [15:0] r_rrem [READY_DEPTH];
    logic [7:0]  r_rpri [READY_DEPTH];
    logic        r_run_v;
    logic [15:0] r_run_id, r_run_rem;
    logic [31:0] r_run_arr, r_now;
    logic [7:0]  r_run_pri;
    t_cmd        r_c;
    logic [SW-1:0] r_idx, r_best;
    logic        r_best_v;
    logic [31:0] w_fin, w_gap;
    logic        w_retire, w_any_free;
    logic [SW-1:0] w_free;

    assign w_fin = r_now + 32'(r_run_rem);
    assign w_gap = r_c.arrival_time - r_now;
    assign w_retire = r_run_v && ((r_c.cmd == CMD_DRAIN) ||
        (r_c.arrival_time >= r_now && w_gap >= 32'(r_run_rem)));

    always_comb begin
        w_any_free = 1'b0;
        w_free = '0;
        for (int i = READY_DEPTH-1; i >= 0; i--) begin
            if (!r_vld[i]) begin
                w_any_free = 1'b1;
                w_free = SW'(i);
            end
        end
    end

    assign o_cmd_take = (r_st == S_IDLE) && i_cmd_valid;
    assign o_res_push = ((r_st == S_EMIT) || (r_st == S_DROP)) && !i_res_full;

    always_comb begin
        o_res = '0;
        if (r_st == S_DROP) begin
            o_res.kind = KIND_DROP;
            o_res.done_id = r_c.job_id;
            o_res.finish_time = r_c.arrival_time;
            o_res.last = 1'b1;
        end else begin
            o_res.kind = KIND_DONE;
            o_res.done_id = r_run_id;
            o_res.finish_time = w_fin;
            // last if after retiring nothing more will be reported
            if (r_c.cmd == CMD_DRAIN) begin
                o_res.last = !r_best_v;
            end else begin
                o_res.last = r_best_v ? !(r_c.arrival_time >= w_fin &&
                    (r_c.arrival_time - w_fin) >= 32'(r_rrem[r_best])) : 1'b1;
            end
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:  if (i_cmd_valid) n_st = S_CHECK;
            S_CHECK: n_st = w_retire ? S_SCAN : (r_c.cmd == CMD_DRAIN ? S_IDLE :
                            ((r_run_v && !w_any_free) ? S_DROP : S_ADMIT));
            S_SCAN:  if (r_idx == SW'(READY_DEPTH-1)) n_st = S_EMIT;
            S_EMIT:  if (!i_res_full) n_st = S_CHECK;
            S_ADMIT: n_st = S_IDLE;
            S_DROP:  if (!i_res_full) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_c <= i_cmd;
        end
        if (r_st == S_CHECK) begin
            r_idx <= '0;
        end else if (r_st == S_SCAN && r_idx != SW'(READY_DEPTH-1)) begin
            r_idx <= r_idx + 1'b1;
        end
        if (r_st == S_SCAN && r_vld[r_idx] && (!r_best_v ||
            beats(r_rpri[r_idx], r_rarr[r_idx], r_rpri[r_best], r_rarr[r_best]))) begin
            r_best <= r_idx;
        end
        if (r_st == S_ADMIT && r_run_v) begin
            if (beats(r_c.job_priority, r_c.arrival_time, r_run_pri, r_run_arr)) begin
                r_rid[w_free]  <= r_run_id;
                r_rarr[w_free] <= r_run_arr;
                r_rrem[w_free] <= (r_c.arrival_time > r_now) ?
                                  r_run_rem - w_gap[15:0] : r_run_rem;
                r_rpri[w_free] <= r_run_pri;
            end else begin
                r_rid[w_free]  <= r_c.job_id;
                r_rarr[w_free] <= r_c.arrival_time;
                r_rrem[w_free] <= r_c.run_length;
                r_rpri[w_free] <= r_c.job_priority;
            end
        end
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_vld <= '0;
            r_run_v <= 1'b0;
            r_run_id <= '0;
            r_run_arr <= '0;
            r_run_rem <= '0;
            r_run_pri <= '0;
            r_now <= '0;
            r_best_v <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == S_CHECK) begin
                r_best_v <= 1'b0;
            end else if (r_st == S_SCAN && r_vld[r_idx]) begin
                r_best_v <= 1'b1;
            end
            if (r_st == S_EMIT && !i_res_full) begin
                r_now <= w_fin;
                r_run_v <= r_best_v;
                if (r_best_v) begin
                    r_run_id  <= r_rid[r_best];
                    r_run_arr <= r_rarr[r_best];
                    r_run_rem <= r_rrem[r_best];
                    r_run_pri <= r_rpri[r_best];
                    r_vld[r_best] <= 1'b0;
                end
            end
            if (r_st == S_ADMIT) begin
                if (r_c.arrival_time > r_now) begin
                    r_now <= r_c.arrival_time;
                end
                if (!r_run_v || beats(r_c.job_priority, r_c.arrival_time,
                                      r_run_pri, r_run_arr)) begin
                    r_run_v   <= 1'b1;
                    r_run_id  <= r_c.job_id;
                    r_run_arr <= r_c.arrival_time;
                    r_run_rem <= r_c.run_length;
                    r_run_pri <= r_c.job_priority;
                end else if (r_c.arrival_time > r_now) begin
                    r_run_rem <= r_run_rem - w_gap[15:0];
                end
                if (r_run_v) begin
                    r_vld[w_free] <= 1'b1;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |=> r_st == S_CHECK) else $error("command taken outside idle");
    a_push_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full) else $error("result pushed into full queue");
    a_drop_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_DROP) |-> (r_run_v && (&r_vld))) else $error("drop with free slot");
`endif
endmodule

/* tb/sv/pps_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pps_checker
// scoreboard for the preemptive priority scheduler
// ---------------------------------------------------------------------------
// watches the command and result queues of the scheduler, keeps its own
// copy of the ready store and the running job, works out the completion and
// drop words each accepted command causes, and compares every popped word
// with the oldest one still owed
// ---------------------------------------------------------------------------
module pps_checker import pps_pkg::*; #(
    parameter int READY_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic        i_cmd,
    input  logic [15:0] i_job_id,
    input  logic [31:0] i_arrival_time,
    input  logic [15:0] i_run_length,
    input  logic [7:0]  i_job_priority,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic        i_kind,
    input  logic [15:0] i_done_id,
    input  logic [31:0] i_finish_time,
    input  logic        i_last,
    output int          o_errors,
    output int          o_owed,
    output int          o_words,
    output int          o_drops
);
    typedef struct {
        logic [15:0] id;
        logic [31:0] arr;
        logic [15:0] rem;
        logic [7:0]  pri;
    } t_job;

    t_res        owed_words[$];
    logic        slot_used[READY_DEPTH];
    t_job        slot_job[READY_DEPTH];
    logic        cpu_busy;
    t_job        cpu_job;
    logic [31:0] clock_now;

    assign o_owed = owed_words.size();

    function automatic logic outranks(t_job a, t_job b);
        if (a.pri != b.pri) begin
            return a.pri > b.pri;
        end
        return a.arr < b.arr;
    endfunction

    function automatic void load_best();
        int best;
        best = -1;
        for (int i = 0; i < READY_DEPTH; i++) begin
            if (slot_used[i] && (best < 0 || outranks(slot_job[i], slot_job[best]))) begin
                best = i;
            end
        end
        cpu_busy = (best >= 0);
        if (best >= 0) begin
            cpu_job = slot_job[best];
            slot_used[best] = 1'b0;
        end
    endfunction

    function automatic void finish_running();
        t_res w;
        w.kind        = KIND_DONE;
        w.done_id     = cpu_job.id;
        w.finish_time = clock_now + 32'(cpu_job.rem);
        w.last        = 1'b0;
        clock_now     = w.finish_time;
        owed_words.insert(owed_words.size(), w);
        load_best();
    endfunction

    function automatic void schedule(t_cmd c);
        int   first;
        int   slot;
        t_job nj;
        t_res w;
        first = owed_words.size();
        slot  = -1;
        nj.id = c.job_id;
        nj.arr = c.arrival_time;
        nj.rem = c.run_length;
        nj.pri = c.job_priority;
        if (c.cmd == CMD_DRAIN) begin
            while (cpu_busy) finish_running();
        end else begin
            while (cpu_busy && c.arrival_time >= clock_now &&
                   c.arrival_time - clock_now >= 32'(cpu_job.rem)) begin
                finish_running();
            end
            if (!cpu_busy) begin
                cpu_busy = 1'b1;
                cpu_job  = nj;
                if (c.arrival_time > clock_now) clock_now = c.arrival_time;
            end else begin
                for (int i = READY_DEPTH - 1; i >= 0; i--) begin
                    if (!slot_used[i]) slot = i;
                end
                if (slot < 0) begin
                    w.kind = KIND_DROP;
                    w.done_id = c.job_id;
                    w.finish_time = c.arrival_time;
                    w.last = 1'b0;
                    owed_words.insert(owed_words.size(), w);
                    o_drops++;
                end else begin
                    if (c.arrival_time > clock_now) begin
                        cpu_job.rem = cpu_job.rem - 16'(c.arrival_time - clock_now);
                        clock_now = c.arrival_time;
                    end
                    slot_used[slot] = 1'b1;
                    if (outranks(nj, cpu_job)) begin
                        slot_job[slot] = cpu_job;
                        cpu_job = nj;
                    end else begin
                        slot_job[slot] = nj;
                    end
                end
            end
        end
        if (owed_words.size() > first) begin
            owed_words[owed_words.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_words = 0;
        o_drops = 0;
        cpu_busy = 1'b0;
        clock_now = '0;
        for (int i = 0; i < READY_DEPTH; i++) slot_used[i] = 1'b0;
    end

    always @(posedge i_clk) begin
        t_cmd c;
        t_res w;
        if (i_rst_n) begin
            if (i_pop && !i_empty) begin
                o_words++;
                if (owed_words.size() == 0) begin
                    report("unexpected word id", 32'(i_done_id), 32'hffffffff);
                end else begin
                    w = owed_words.pop_front();
                    if (i_kind != w.kind) report("kind", 32'(i_kind), 32'(w.kind));
                    if (i_done_id != w.done_id) report("done_id", 32'(i_done_id), 32'(w.done_id));
                    if (i_finish_time != w.finish_time) begin
                        report("finish_time", i_finish_time, w.finish_time);
                    end
                    if (i_last != w.last) report("last", 32'(i_last), 32'(w.last));
                end
            end
            if (i_push && !i_full) begin
                c = '{i_cmd, i_job_id, i_arrival_time, i_run_length, i_job_priority};
                schedule(c);
            end
        end
    end
endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// stimulus and verdict for the preemptive priority scheduler
// ---------------------------------------------------------------------------
// directed corner words, then random bursts of arrivals with rising times,
// drains and time wrap, with random gaps on both sides, a long reader stall
// to fill the block and a sender pause until all words are back
// ---------------------------------------------------------------------------
module tb;
    import pps_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 900000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic        o_full;
    logic        i_cmd = CMD_ARRIVE;
    logic [15:0] i_job_id = '0;
    logic [31:0] i_arrival_time = '0;
    logic [15:0] i_run_length = '0;
    logic [7:0]  i_job_priority = '0;
    logic        o_empty;
    logic        i_pop = 1'b0;
    logic        o_kind;
    logic [15:0] o_done_id;
    logic [31:0] o_finish_time;
    logic        o_last;
    int          errors, owed, words, drops;
    int          cycles = 0;
    int          hold_off = 0;
    logic [31:0] tick = '0;
    int          jobs_sent = 0;

    always #6 i_clk = ~i_clk;

    preemptive_priority_scheduler #(.READY_DEPTH(DEPTH)) u_dut (.*);

    pps_checker #(.READY_DEPTH(DEPTH)) u_chk (
        .i_clk, .i_rst_n, .i_push, .i_full(o_full), .i_cmd, .i_job_id,
        .i_arrival_time, .i_run_length, .i_job_priority, .i_empty(o_empty),
        .i_pop, .i_kind(o_kind), .i_done_id(o_done_id), .i_finish_time(o_finish_time),
        .i_last(o_last),
        .o_errors(errors), .o_owed(owed), .o_words(words), .o_drops(drops)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // reader: random gaps per word, or a long stall when asked
    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            gap = (hold_off > 0) ? hold_off : $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (hold_off > 0) begin
                gap = hold_off;
                hold_off = 0;
            end
            if (gap > 0) begin
                i_pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_pop <= 1'b1;
            do @(posedge i_clk); while (o_empty);
        end
    end

    task automatic send(logic cmd, logic [15:0] id, logic [31:0] arr,
                        logic [15:0] len, logic [7:0] pri, int gap);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push         <= 1'b1;
        i_cmd          <= cmd;
        i_job_id       <= id;
        i_arrival_time <= arr;
        i_run_length   <= len;
        i_job_priority <= pri;
        do @(posedge i_clk); while (o_full);
        if (cmd == CMD_ARRIVE) jobs_sent++;
    endtask

    task automatic arrive(logic [31:0] step, logic [15:0] len, logic [7:0] pri, int gap);
        tick = tick + step;
        send(CMD_ARRIVE, 16'($urandom), tick, len, pri, gap);
    endtask

    task automatic settle();
        i_push <= 1'b0;
        @(posedge i_clk);
        wait (owed == 0);
        repeat (60) @(posedge i_clk);
    endtask

    initial begin
        int mode;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: drain while idle, extremes, ties, zero length, full store
        send(CMD_DRAIN, 16'hffff, '1, '1, '1, 0);
        send(CMD_ARRIVE, 16'h0000, '0, 16'hffff, 8'h00, 0);
        send(CMD_ARRIVE, 16'hffff, '0, 16'h0001, 8'hff, 0);
        send(CMD_ARRIVE, 16'h1234, '0, 16'h0000, 8'hff, 0);
        send(CMD_ARRIVE, 16'h5678, 32'd5, 16'h0003, 8'h00, 0);
        send(CMD_DRAIN, '0, '0, '0, '0, 0);
        send(CMD_ARRIVE, 16'h0010, 32'h100, 16'd50, 8'd7, 0);
        for (int i = 0; i < 18; i++) begin
            send(CMD_ARRIVE, 16'(16'h20 + i), 32'h100, 16'(i + 1), 8'($urandom), 0);
        end
        send(CMD_ARRIVE, 16'haaaa, 32'h80, 16'd4, 8'd1, 0);
        send(CMD_DRAIN, '0, '0, '0, '0, 0);
        send(CMD_ARRIVE, 16'hbeef, 32'hffff_fff0, 16'hffff, 8'd3, 0);
        send(CMD_ARRIVE, 16'hcafe, 32'hffff_fff8, 16'h0010, 8'd3, 0);
        send(CMD_DRAIN, '0, '0, '0, '0, 0);
        settle();
        tick = 32'd1000;

        // long reader stall while the sender keeps pushing
        hold_off = 3000;
        for (int i = 0; i < 30; i++) arrive($urandom_range(0, 40), 16'($urandom_range(1, 60)),
                                            8'($urandom_range(0, 3)), 0);
        send(CMD_DRAIN, '0, '0, '0, '0, 0);
        settle();

        while (jobs_sent < 390) begin
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                send(CMD_DRAIN, '0, '0, '0, '0, $urandom_range(0, 6));
            end else if (mode == 1) begin
                tick = $urandom_range(0, 1) ? '1 - 32'($urandom_range(0, 300)) : $urandom;
                arrive('0, 16'($urandom), 8'($urandom), $urandom_range(0, 6));
            end else if (mode == 2) begin
                send(CMD_ARRIVE, 16'($urandom), $urandom, 16'($urandom), 8'($urandom),
                     $urandom_range(0, 6));
            end else begin
                arrive($urandom_range(0, 1) ? 32'($urandom_range(0, 20)) : 32'($urandom_range(0, 3000)),
                       16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200)),
                       8'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 3)),
                       $urandom_range(0, 1) ? 0 : $urandom_range(0, 6));
            end
            if ($urandom_range(0, 60) == 0) settle();
        end
        send(CMD_DRAIN, '0, '0, '0, '0, 0);
        settle();

        $display("sent %0d arrivals plus drains, checked %0d result words, %0d drops",
                 jobs_sent, words, drops);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
